/* rtl/flac_frame_block_size_parser_top_macros.svh */
// Assertion macros shared by the FLAC frame block size parser RTL.
`ifndef FLAC_FRAME_BLOCK_SIZE_PARSER_TOP_MACROS_SVH
`define FLAC_FRAME_BLOCK_SIZE_PARSER_TOP_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define FBS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define FBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/flac_fbs_pkg.sv */
// Shared types and constants of the FLAC frame block size parser.
package flac_fbs_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned CNT_W   = 17;

  localparam logic REG_MIN_BLOCK_SIZE = 1'b0;
  localparam logic REG_MAX_BLOCK_SIZE = 1'b1;

  localparam logic [SIZE_W-1:0] RESET_BLOCK_SIZE = 16'd4096;

  typedef struct packed {
    logic             has;
    logic             ok;
    logic [CNT_W-1:0] count;
  } res_t;

  typedef struct packed {
    logic [SIZE_W-1:0] min_size;
    logic [SIZE_W-1:0] max_size;
  } cfg_t;

endpackage

/* rtl/flac_fbs_regs.sv */
// Configuration register file with its APB-style access port.
module flac_fbs_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [flac_fbs_pkg::PADDR_W-1:0]    paddr,
  input  logic [flac_fbs_pkg::PDATA_W-1:0]    pwdata,
  output logic [flac_fbs_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready,
  output flac_fbs_pkg::cfg_t                  cfg
);

  logic [flac_fbs_pkg::SIZE_W-1:0] min_size;
  logic [flac_fbs_pkg::SIZE_W-1:0] max_size;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size <= flac_fbs_pkg::RESET_BLOCK_SIZE;
      max_size <= flac_fbs_pkg::RESET_BLOCK_SIZE;
    end else if (wr_en) begin
      case (paddr[2])
        flac_fbs_pkg::REG_MIN_BLOCK_SIZE: min_size <= pwdata[flac_fbs_pkg::SIZE_W-1:0];
        flac_fbs_pkg::REG_MAX_BLOCK_SIZE: max_size <= pwdata[flac_fbs_pkg::SIZE_W-1:0];
        default: min_size <= min_size;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      flac_fbs_pkg::REG_MIN_BLOCK_SIZE:
        prdata = {{(flac_fbs_pkg::PDATA_W-flac_fbs_pkg::SIZE_W){1'b0}}, min_size};
      flac_fbs_pkg::REG_MAX_BLOCK_SIZE:
        prdata = {{(flac_fbs_pkg::PDATA_W-flac_fbs_pkg::SIZE_W){1'b0}}, max_size};
      default: prdata = '0;
    endcase
  end

  assign cfg.min_size = min_size;
  assign cfg.max_size = max_size;

endmodule

/* rtl/flac_fbs_core.sv */
// Header parse state machine: one byte item per step, at most one result.
`include "flac_frame_block_size_parser_top_macros.svh"

module flac_fbs_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  logic [7:0]               data_byte,
  input  logic                     frame_start,
  input  logic                     buffer_end,
  input  flac_fbs_pkg::cfg_t       cfg,
  output flac_fbs_pkg::res_t       res
);

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_CODE,
    PH_RATECH,
    PH_LEAD,
    PH_SKIP,
    PH_CNTHI,
    PH_CNTLO,
    PH_CRC
  } phase_t;

  localparam logic [7:0] SYNC_FIRST = 8'hFF;
  localparam logic [7:0] SYNC2_MASK = 8'hFC;
  localparam logic [7:0] SYNC2_BITS = 8'hF8;
  localparam logic [3:0] CODE_MIN   = 4'd0;
  localparam logic [3:0] CODE_192   = 4'd1;
  localparam logic [3:0] CODE_CNT8  = 4'd6;
  localparam logic [3:0] CODE_CNT16 = 4'd7;

  phase_t                         phase;
  phase_t                         phase_next;
  logic [3:0]                     size_code;
  logic [3:0]                     size_code_next;
  logic [2:0]                     skip;
  logic [2:0]                     skip_next;
  logic [2:0]                     skip_dec;
  logic [flac_fbs_pkg::CNT_W-1:0] acc;
  logic [flac_fbs_pkg::CNT_W-1:0] acc_next;
  logic [flac_fbs_pkg::CNT_W-1:0] code_count;
  logic [3:0]                     new_code;
  logic                           lead_ok;
  logic [2:0]                     lead_len;
  logic                           bad;
  logic                           done;
  logic                           ignored;
  phase_t                         after_number;

  function automatic phase_t phase_after(input logic [3:0] code);
    if (code == CODE_CNT8) begin
      return PH_CNTLO;
    end else if (code == CODE_CNT16) begin
      return PH_CNTHI;
    end
    return PH_CRC;
  endfunction

  assign new_code     = data_byte[7:4];
  assign skip_dec     = skip - 3'd1;
  assign after_number = phase_after(size_code);

  always_comb begin
    if (new_code == CODE_MIN) begin
      code_count = {1'b0, cfg.min_size};
    end else if (new_code == CODE_192) begin
      code_count = flac_fbs_pkg::CNT_W'(192);
    end else if (new_code[3]) begin
      code_count = flac_fbs_pkg::CNT_W'(256) << new_code[2:0];
    end else if (new_code == CODE_CNT8 || new_code == CODE_CNT16) begin
      code_count = '0;
    end else begin
      code_count = flac_fbs_pkg::CNT_W'(576) << 2'(new_code - 4'd2);
    end
  end

  always_comb begin
    lead_ok  = 1'b1;
    lead_len = 3'd0;
    if (!data_byte[7]) begin
      lead_len = 3'd0;
    end else if (data_byte[7:5] == 3'b110) begin
      lead_len = 3'd1;
    end else if (data_byte[7:4] == 4'b1110) begin
      lead_len = 3'd2;
    end else if (data_byte[7:3] == 5'b11110) begin
      lead_len = 3'd3;
    end else if (data_byte[7:2] == 6'b111110) begin
      lead_len = 3'd4;
    end else if (data_byte[7:1] == 7'b1111110) begin
      lead_len = 3'd5;
    end else if (data_byte == 8'hFE) begin
      lead_len = 3'd6;
      lead_ok  = cfg.min_size != cfg.max_size;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    phase_next     = phase;
    size_code_next = size_code;
    skip_next      = skip;
    acc_next       = acc;
    bad            = 1'b0;
    done           = 1'b0;
    ignored        = 1'b0;
    if (frame_start) begin
      if (data_byte == SYNC_FIRST) begin
        phase_next = PH_SYNC2;
      end else begin
        bad = 1'b1;
      end
    end else begin
      case (phase)
        PH_SYNC2: begin
          if ((data_byte & SYNC2_MASK) == SYNC2_BITS) begin
            phase_next = PH_CODE;
          end else begin
            bad = 1'b1;
          end
        end
        PH_CODE: begin
          size_code_next = new_code;
          acc_next       = code_count;
          phase_next     = PH_RATECH;
        end
        PH_RATECH: phase_next = PH_LEAD;
        PH_LEAD: begin
          if (!lead_ok) begin
            bad = 1'b1;
          end else if (lead_len == 3'd0) begin
            phase_next = after_number;
          end else begin
            skip_next  = lead_len;
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_next = skip_dec;
          if (skip_dec == 3'd0) begin
            phase_next = after_number;
          end
        end
        PH_CNTHI: begin
          acc_next   = {1'b0, data_byte, 8'h00};
          phase_next = PH_CNTLO;
        end
        PH_CNTLO: begin
          acc_next   = (acc | {{(flac_fbs_pkg::CNT_W-8){1'b0}}, data_byte})
                       + flac_fbs_pkg::CNT_W'(1);
          phase_next = PH_CRC;
        end
        PH_CRC: done = 1'b1;
        default: begin
          phase_next = PH_IDLE;
          ignored    = 1'b1;
        end
      endcase
    end

    res.has   = 1'b0;
    res.ok    = 1'b0;
    res.count = '0;
    if (done) begin
      phase_next = PH_IDLE;
      res.has    = 1'b1;
      res.ok     = 1'b1;
      res.count  = acc;
    end else if ((bad || buffer_end) && !ignored) begin
      phase_next = PH_IDLE;
      res.has    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      size_code <= '0;
      skip      <= '0;
      acc       <= '0;
    end else if (step) begin
      phase     <= phase_next;
      size_code <= size_code_next;
      skip      <= skip_next;
      acc       <= acc_next;
    end
  end

  `FBS_ASSERT(a_skip_nonzero, clk, rst, phase == PH_SKIP |-> skip != 3'd0, "skip phase with no bytes left")
  `FBS_ASSERT(a_idle_after_result, clk, rst, step && res.has |=> phase == PH_IDLE, "parser not idle after a result")
  `FBS_ASSERT(a_bad_is_zero, clk, rst, res.has && !res.ok |-> res.count == '0, "failed parse with nonzero count")

endmodule

/* rtl/flac_frame_block_size_parser_top.sv */
// Top level of the FLAC frame block size parser.
// A byte item accepted into the input register gives its result item through the result register.
// Throughput: one byte item per cycle while the output is not stalled; the parser state
// machine steps only when the input register holds an item and the result register is free.
// Reset (synchronous, rst high) empties both registers, idles the parser and
// sets both block size registers to 4096.
`include "flac_frame_block_size_parser_top_macros.svh"

module flac_frame_block_size_parser_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       data_byte,
  input  logic                             frame_start,
  input  logic                             buffer_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [flac_fbs_pkg::CNT_W-1:0]   sample_count,
  output logic                             valid_res,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [flac_fbs_pkg::PADDR_W-1:0] paddr,
  input  logic [flac_fbs_pkg::PDATA_W-1:0] pwdata,
  output logic [flac_fbs_pkg::PDATA_W-1:0] prdata,
  output logic                             pready
);

  flac_fbs_pkg::cfg_t cfg;
  flac_fbs_pkg::res_t res;

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;
  logic       s1_end;
  logic       out_free;
  logic       step;

  assign out_free = !out_valid || out_ready;
  assign step     = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  flac_fbs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  flac_fbs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .data_byte   (s1_byte),
    .frame_start (s1_start),
    .buffer_end  (s1_end),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte  <= data_byte;
      s1_start <= frame_start;
      s1_end   <= buffer_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.has;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.has) begin
      sample_count <= res.count;
      valid_res    <= res.ok;
    end
  end

  `FBS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && !s1_valid, "registers not empty after reset")
  `FBS_ASSERT(a_hold_stalled, clk, rst, s1_valid && !out_free |=> s1_valid && $stable(s1_byte), "stalled input item lost")
  `FBS_ASSERT(a_invalid_zero, clk, rst, out_valid && !valid_res |-> sample_count == '0, "invalid result with nonzero count")

endmodule

/* test/tb_flac_frame_block_size_parser_top.sv */
// Self-checking testbench for the FLAC frame block size parser: header bytes in, sample counts out.
module tb_flac_frame_block_size_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    HDR_IDLE, HDR_SYNC2, HDR_CODE, HDR_RATE_CH, HDR_LEAD, HDR_SKIP, HDR_CNT_HI, HDR_CNT_LO,
    HDR_CRC
  } hdr_phase_t;

  typedef struct packed {
    logic [7:0] b;
    logic       st;
    logic       en;
  } hdr_byte_t;

  typedef struct packed {
    logic [flac_fbs_pkg::CNT_W-1:0] cnt;
    logic                           ok;
  } frame_count_t;

  typedef struct packed {
    logic [7:0]                     b;
    logic                           st;
    logic                           en;
    logic                           typed;
    logic                           ok;
    logic [flac_fbs_pkg::CNT_W-1:0] cnt;
  } dir_row_t;

  localparam logic [flac_fbs_pkg::PADDR_W-1:0] ADDR_MIN =
    {flac_fbs_pkg::REG_MIN_BLOCK_SIZE, 2'b00};
  localparam logic [flac_fbs_pkg::PADDR_W-1:0] ADDR_MAX =
    {flac_fbs_pkg::REG_MAX_BLOCK_SIZE, 2'b00};

  localparam logic [3:0] CODE_MIN   = 4'd0;
  localparam logic [3:0] CODE_192   = 4'd1;
  localparam logic [3:0] CODE_CNT8  = 4'd6;
  localparam logic [3:0] CODE_CNT16 = 4'd7;

  localparam int DIR_N = 27;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 17'd0},
    '{8'h12, 1'b1, 1'b0, 1'b1, 1'b0, 17'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hF4, 1'b0, 1'b0, 1'b1, 1'b0, 17'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFB, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h0F, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hAB, 1'b0, 1'b0, 1'b1, 1'b1, 17'd4096},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h70, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hC2, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hCC, 1'b0, 1'b0, 1'b1, 1'b1, 17'd65536},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hF0, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 17'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b1, 1'b0, 17'd0},
    '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 17'd0}
  };

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic [7:0]                       data_byte = 8'h00;
  logic                             frame_start = 1'b0;
  logic                             buffer_end = 1'b0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic [flac_fbs_pkg::CNT_W-1:0]   sample_count;
  logic                             valid_res;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [flac_fbs_pkg::PADDR_W-1:0] paddr = '0;
  logic [flac_fbs_pkg::PDATA_W-1:0] pwdata = '0;
  logic [flac_fbs_pkg::PDATA_W-1:0] prdata;
  logic                             pready;

  hdr_phase_t                       hdr_phase = HDR_IDLE;
  logic [3:0]                       size_sel = 4'd0;
  logic [2:0]                       skip_left = 3'd0;
  logic [flac_fbs_pkg::CNT_W-1:0]   count_acc = '0;
  logic [flac_fbs_pkg::SIZE_W-1:0]  min_sz = flac_fbs_pkg::RESET_BLOCK_SIZE;
  logic [flac_fbs_pkg::SIZE_W-1:0]  max_sz = flac_fbs_pkg::RESET_BLOCK_SIZE;

  frame_count_t       pending_counts [$];
  int                 mismatch_count = 0;
  int                 bytes_sent = 0;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 holdoff_seq = 0;
  int                 holdoff_seen = 0;
  int                 holdoff_left = 0;

  flac_frame_block_size_parser_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .frame_start  (frame_start),
    .buffer_end   (buffer_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_count (sample_count),
    .valid_res    (valid_res),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb_flac_frame_block_size_parser_top NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int lead_extra_bytes(input logic [7:0] b);
    if (!b[7]) return 0;
    if (b[7:5] == 3'b110) return 1;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:3] == 5'b11110) return 3;
    if (b[7:2] == 6'b111110) return 4;
    if (b[7:1] == 7'b1111110) return 5;
    if (b == 8'hFE && min_sz != max_sz) return 6;
    return -1;
  endfunction

  function automatic hdr_phase_t phase_after_number();
    if (size_sel == CODE_CNT8) return HDR_CNT_LO;
    if (size_sel == CODE_CNT16) return HDR_CNT_HI;
    return HDR_CRC;
  endfunction

  function automatic logic predict_frame_count(input hdr_byte_t it, output frame_count_t res);
    logic bad;
    logic done;
    int   n;
    bad = 1'b0;
    done = 1'b0;
    res = '0;
    if (it.st) begin
      if (it.b == 8'hFF) hdr_phase = HDR_SYNC2;
      else bad = 1'b1;
    end else begin
      case (hdr_phase)
        HDR_SYNC2: begin
          if (it.b[7:2] == 6'b111110) hdr_phase = HDR_CODE;
          else bad = 1'b1;
        end
        HDR_CODE: begin
          size_sel = it.b[7:4];
          if (size_sel == CODE_MIN) count_acc = flac_fbs_pkg::CNT_W'(min_sz);
          else if (size_sel == CODE_192) count_acc = 17'd192;
          else if (size_sel <= 4'd5) count_acc = 17'd576 << (size_sel - 4'd2);
          else if (size_sel >= 4'd8) count_acc = 17'd256 << (size_sel - 4'd8);
          else count_acc = '0;
          hdr_phase = HDR_RATE_CH;
        end
        HDR_RATE_CH: hdr_phase = HDR_LEAD;
        HDR_LEAD: begin
          n = lead_extra_bytes(it.b);
          if (n < 0) begin
            bad = 1'b1;
          end else if (n == 0) begin
            hdr_phase = phase_after_number();
          end else begin
            skip_left = 3'(n);
            hdr_phase = HDR_SKIP;
          end
        end
        HDR_SKIP: begin
          skip_left = skip_left - 3'd1;
          if (skip_left == 3'd0) hdr_phase = phase_after_number();
        end
        HDR_CNT_HI: begin
          count_acc = {1'b0, it.b, 8'h00};
          hdr_phase = HDR_CNT_LO;
        end
        HDR_CNT_LO: begin
          count_acc = (count_acc | flac_fbs_pkg::CNT_W'(it.b)) + 17'd1;
          hdr_phase = HDR_CRC;
        end
        HDR_CRC: done = 1'b1;
        default: begin
          hdr_phase = HDR_IDLE;
          return 1'b0;
        end
      endcase
    end
    if (done) begin
      hdr_phase = HDR_IDLE;
      res.cnt = count_acc;
      res.ok = 1'b1;
      return 1'b1;
    end
    if (bad || it.en) begin
      hdr_phase = HDR_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hdr_byte_t plain(input logic [7:0] b);
    hdr_byte_t it;
    it.b = b;
    it.st = 1'b0;
    it.en = 1'b0;
    return it;
  endfunction

  task automatic send_byte(input hdr_byte_t it, input logic use_row, input frame_count_t row_res);
    frame_count_t res;
    logic         has;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= it.b;
    frame_start <= it.st;
    buffer_end <= it.en;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has = predict_frame_count(it, res);
    if (use_row) pending_counts.push_back(row_res);
    else if (has) pending_counts.push_back(res);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [flac_fbs_pkg::PADDR_W-1:0] addr,
                           input logic [flac_fbs_pkg::SIZE_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= flac_fbs_pkg::PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_check(input logic [flac_fbs_pkg::PADDR_W-1:0] addr,
                           input logic [flac_fbs_pkg::SIZE_W-1:0] want);
    logic [flac_fbs_pkg::PDATA_W-1:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got[flac_fbs_pkg::SIZE_W-1:0] !== want)
      report_mismatch($sformatf("register at %0d reads %0d, want %0d", addr, got, want));
  endtask

  task automatic set_block_sizes(input logic [flac_fbs_pkg::SIZE_W-1:0] mn,
                                 input logic [flac_fbs_pkg::SIZE_W-1:0] mx);
    apb_write(ADDR_MIN, mn);
    apb_write(ADDR_MAX, mx);
    min_sz = mn;
    max_sz = mx;
    apb_check(ADDR_MIN, mn);
    apb_check(ADDR_MAX, mx);
  endtask

  task automatic send_random_frame();
    hdr_byte_t  f [$];
    hdr_byte_t  it;
    int         kind;
    int         code;
    int         n;
    int         pos;
    logic [7:0] r;
    kind = $urandom_range(99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) begin
        it.b = 8'($urandom);
        it.st = ($urandom_range(3) == 0);
        it.en = ($urandom_range(7) == 0);
        f.push_back(it);
      end
    end else begin
      code = $urandom_range(19);
      if (code >= 16) code = (code < 18) ? int'(CODE_CNT8) : int'(CODE_CNT16);
      it = plain(8'hFF);
      it.st = 1'b1;
      f.push_back(it);
      f.push_back(plain(8'hF8 | 8'($urandom_range(3))));
      f.push_back(plain({4'(code), 4'($urandom)}));
      f.push_back(plain(8'($urandom)));
      n = $urandom_range(6);
      r = 8'($urandom);
      case (n)
        0: r[7] = 1'b0;
        1: r[7:5] = 3'b110;
        2: r[7:4] = 4'b1110;
        3: r[7:3] = 5'b11110;
        4: r[7:2] = 6'b111110;
        5: r[7:1] = 7'b1111110;
        default: r = 8'hFE;
      endcase
      f.push_back(plain(r));
      repeat (n) f.push_back(plain(8'($urandom)));
      if (code == int'(CODE_CNT16)) f.push_back(plain(8'($urandom)));
      if (code == int'(CODE_CNT8) || code == int'(CODE_CNT16))
        f.push_back(plain(8'($urandom)));
      f.push_back(plain(8'($urandom)));
      if (kind < 36) begin
        pos = $urandom_range(f.size() - 1);
        case ($urandom_range(4))
          0: f[0].b = 8'($urandom_range(254));
          1: begin
            r = 8'($urandom);
            if (r[7:2] == 6'b111110) r[2] = 1'b1;
            f[1].b = r;
          end
          2: f[4].b = $urandom_range(1) ? 8'hFF : {2'b10, 6'($urandom)};
          3: f[pos].st = 1'b1;
          default: f[pos].en = 1'b1;
        endcase
      end
    end
    foreach (f[i]) send_byte(f[i], 1'b0, '0);
  endtask

  task automatic run_phase(input logic [flac_fbs_pkg::SIZE_W-1:0] mn,
                           input logic [flac_fbs_pkg::SIZE_W-1:0] mx,
                           input int s_idle, input int r_stall, input int n_items,
                           input logic holdoff, input logic pause);
    int   goal;
    logic paused;
    paused = 1'b0;
    wait_drained();
    set_block_sizes(mn, mx);
    send_idle_pct = s_idle;
    recv_stall_pct <= r_stall;
    if (holdoff) holdoff_seq <= holdoff_seq + 1;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      send_random_frame();
      if (pause && !paused && bytes_sent >= goal - n_items / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (holdoff_left != 0) begin
      out_ready <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_seq != holdoff_seen) begin
      holdoff_seen <= holdoff_seq;
      holdoff_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_counts
    frame_count_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected result count %0d valid %0b",
                                  sample_count, valid_res));
      end else begin
        want = pending_counts.pop_front();
        if (sample_count !== want.cnt)
          report_mismatch($sformatf("sample_count %0d, want %0d", sample_count, want.cnt));
        if (valid_res !== want.ok)
          report_mismatch($sformatf("valid_res %0b, want %0b", valid_res, want.ok));
      end
    end
  end

  initial begin : stimulus
    hdr_byte_t    it;
    frame_count_t row_res;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    apb_check(ADDR_MIN, flac_fbs_pkg::RESET_BLOCK_SIZE);
    apb_check(ADDR_MAX, flac_fbs_pkg::RESET_BLOCK_SIZE);
    for (int i = 0; i < DIR_N; i++) begin
      it.b = DIR_ROWS[i].b;
      it.st = DIR_ROWS[i].st;
      it.en = DIR_ROWS[i].en;
      row_res.cnt = DIR_ROWS[i].cnt;
      row_res.ok = DIR_ROWS[i].ok;
      send_byte(it, DIR_ROWS[i].typed, row_res);
    end
    run_phase(16'd0, 16'hFFFF, 0, 0, 220, 1'b1, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 64, 0, 220, 1'b0, 1'b1);
    run_phase(16'd0, 16'd0, 0, 64, 220, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 33, 33, 220, 1'b0, 1'b0);
    run_phase(16'd4096, 16'd4095, 0, 0, 220, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'd0, 64, 0, 220, 1'b0, 1'b0);
    run_phase(16'($urandom), 16'($urandom), 0, 64, 220, 1'b0, 1'b0);
    run_phase(16'd1, 16'd1, 33, 33, 220, 1'b0, 1'b0);
    wait_drained();
    if (mismatch_count == 0) begin
      $display("tb_flac_frame_block_size_parser_top OK");
    end else begin
      $display("tb_flac_frame_block_size_parser_top NOT OK");
    end
    $finish;
  end

endmodule
